### rtl/i2cm_pkg.sv
package i2cm_pkg;

  // command codes carried in func
  localparam logic [2:0] FUNC_NONE  = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_STOP  = 3'd4;

  // configuration register indexes
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd1;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  // tick queue between front and engine
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } i2cm_in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       cmd_done;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } i2cm_out_t;

  // queued tick: command already reduced to a known code
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } i2cm_tick_t;

  function automatic i2cm_tick_t i2cm_classify(input i2cm_in_t item);
    i2cm_tick_t t;
    t.tx_byte  = item.tx_byte;
    t.send_ack = item.send_ack;
    t.sda_in   = item.sda_in;
    case (item.func)
      FUNC_START, FUNC_WRITE, FUNC_READ, FUNC_STOP: t.cmd = item.func;
      default: t.cmd = FUNC_NONE;
    endcase
    return t;
  endfunction

endpackage

### rtl/i2cm_front.sv
module i2cm_front import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  i2cm_in_t   in_data,
  output logic       q_valid,
  output i2cm_tick_t q_item,
  input  logic       q_pop
);

  i2cm_tick_t       mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r, count_nxt;
  logic             push;

  assign in_stall = (count_r == (QAW+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= i2cm_classify(in_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

### rtl/i2cm_engine.sv
module i2cm_engine import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic       q_valid,
  input  i2cm_tick_t q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output i2cm_out_t  out_data
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_WRITE = 3'd2;
  localparam logic [2:0] PH_WACK  = 3'd3;
  localparam logic [2:0] PH_POLL  = 3'd4;
  localparam logic [2:0] PH_READ  = 3'd5;
  localparam logic [2:0] PH_RACK  = 3'd6;
  localparam logic [2:0] PH_STOP  = 3'd7;

  logic [15:0] half_period_r;
  logic [7:0]  ack_limit_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;
  logic        half_step_r, half_step_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  wait_cnt_r, wait_cnt_nxt;
  logic [15:0] tick_div_r, tick_div_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        ack_choice_r, ack_choice_nxt;
  logic [7:0]  rx_hold_r, rx_hold_nxt;
  logic        ack_flag_r, ack_flag_nxt;
  logic        done;

  logic        out_valid_r;
  i2cm_out_t   out_r;

  logic [15:0] hp;
  logic [15:0] div_inc;
  logic        half_end;
  logic        step;

  assign step  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = step;

  assign hp       = (half_period_r == '0) ? 16'd1 : half_period_r;
  assign div_inc  = tick_div_r + 16'd1;
  assign half_end = (div_inc >= hp);

  always_comb begin
    phase_nxt      = phase_r;
    bit_idx_nxt    = bit_idx_r;
    half_step_nxt  = half_step_r;
    shift_nxt      = shift_r;
    wait_cnt_nxt   = wait_cnt_r;
    tick_div_nxt   = tick_div_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_choice_nxt = ack_choice_r;
    rx_hold_nxt    = rx_hold_r;
    ack_flag_nxt   = ack_flag_r;
    done           = 1'b0;

    case (phase_r)
      PH_IDLE: begin
        tick_div_nxt  = '0;
        half_step_nxt = 1'b0;
        bit_idx_nxt   = '0;
        case (q_item.cmd)
          FUNC_START: begin
            phase_nxt = PH_START;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
          end
          FUNC_WRITE: begin
            phase_nxt    = PH_WRITE;
            shift_nxt    = q_item.tx_byte;
            ack_flag_nxt = 1'b0;
            scl_nxt      = 1'b0;
            sda_nxt      = q_item.tx_byte[7];
          end
          FUNC_READ: begin
            phase_nxt      = PH_READ;
            shift_nxt      = '0;
            ack_choice_nxt = q_item.send_ack;
            scl_nxt        = 1'b0;
            sda_nxt        = 1'b1;
          end
          FUNC_STOP: begin
            phase_nxt    = PH_STOP;
            tick_div_nxt = '0;
            scl_nxt      = 1'b0;
            sda_nxt      = 1'b0;
          end
          default: ;
        endcase
      end
      PH_POLL: begin
        if (!q_item.sda_in) begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end else if (wait_cnt_r >= ack_limit_r) begin
          // no acknowledge: flag it and release the bus
          ack_flag_nxt = 1'b1;
          phase_nxt    = PH_STOP;
          bit_idx_nxt  = '0;
          tick_div_nxt = '0;
          scl_nxt      = 1'b0;
          sda_nxt      = 1'b0;
        end else begin
          wait_cnt_nxt = wait_cnt_r + 8'd1;
        end
      end
      default: begin
        tick_div_nxt = half_end ? 16'd0 : div_inc;
        if (half_end) begin
          case (phase_r)
            PH_START: begin
              if (!half_step_r) begin
                sda_nxt       = 1'b0;
                half_step_nxt = 1'b1;
              end else begin
                scl_nxt   = 1'b0;
                phase_nxt = PH_IDLE;
                done      = 1'b1;
              end
            end
            PH_WRITE: begin
              if (!half_step_r) begin
                scl_nxt       = 1'b1;
                half_step_nxt = 1'b1;
              end else begin
                scl_nxt       = 1'b0;
                half_step_nxt = 1'b0;
                if (bit_idx_r == 3'd7) begin
                  // release SDA while SCL is low, ahead of the ACK clock
                  sda_nxt   = 1'b1;
                  phase_nxt = PH_WACK;
                end else begin
                  bit_idx_nxt = bit_idx_r + 3'd1;
                  shift_nxt   = {shift_r[6:0], 1'b0};
                  sda_nxt     = shift_r[6];
                end
              end
            end
            PH_WACK: begin
              if (!half_step_r) begin
                scl_nxt       = 1'b1;
                half_step_nxt = 1'b1;
              end else begin
                phase_nxt    = PH_POLL;
                wait_cnt_nxt = '0;
              end
            end
            PH_READ: begin
              if (!half_step_r) begin
                scl_nxt       = 1'b1;
                half_step_nxt = 1'b1;
              end else begin
                shift_nxt     = {shift_r[6:0], q_item.sda_in};
                scl_nxt       = 1'b0;
                half_step_nxt = 1'b0;
                if (bit_idx_r == 3'd7) begin
                  phase_nxt = PH_RACK;
                  sda_nxt   = !ack_choice_r;
                end else begin
                  bit_idx_nxt = bit_idx_r + 3'd1;
                end
              end
            end
            PH_RACK: begin
              if (!half_step_r) begin
                scl_nxt       = 1'b1;
                half_step_nxt = 1'b1;
              end else begin
                scl_nxt     = 1'b0;
                sda_nxt     = 1'b1;
                rx_hold_nxt = shift_r;
                phase_nxt   = PH_IDLE;
                done        = 1'b1;
              end
            end
            default: begin
              // stop sequence: raise SCL, then release SDA, then finish
              if (bit_idx_r == 3'd0) begin
                scl_nxt     = 1'b1;
                bit_idx_nxt = 3'd1;
              end else if (bit_idx_r == 3'd1) begin
                sda_nxt     = 1'b1;
                bit_idx_nxt = 3'd2;
              end else begin
                phase_nxt   = PH_IDLE;
                bit_idx_nxt = '0;
                done        = 1'b1;
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      ack_limit_r   <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period_r <= cfg_wdata;
        CFG_ACK_TIMEOUT: ack_limit_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_idx_r    <= '0;
      half_step_r  <= 1'b0;
      shift_r      <= '0;
      wait_cnt_r   <= '0;
      tick_div_r   <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      ack_choice_r <= 1'b0;
      rx_hold_r    <= '0;
      ack_flag_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= step || (out_valid_r && out_stall);
      if (step) begin
        phase_r      <= phase_nxt;
        bit_idx_r    <= bit_idx_nxt;
        half_step_r  <= half_step_nxt;
        shift_r      <= shift_nxt;
        wait_cnt_r   <= wait_cnt_nxt;
        tick_div_r   <= tick_div_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        ack_choice_r <= ack_choice_nxt;
        rx_hold_r    <= rx_hold_nxt;
        ack_flag_r   <= ack_flag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r.scl_level   <= scl_nxt;
      out_r.sda_release <= sda_nxt;
      out_r.busy_res    <= (phase_nxt != PH_IDLE);
      out_r.cmd_done    <= done;
      out_r.rx_byte     <= rx_hold_nxt;
      out_r.ack_missing <= ack_flag_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.cmd_done |-> !out_r.busy_res)
    else $error("done result still shows busy");

  a_poll_scl_high: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_POLL |-> scl_r)
    else $error("SCL low while polling for acknowledge");

  a_stop_step: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STOP |-> bit_idx_r <= 3'd2)
    else $error("stop sequence step out of range");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_r) && $stable(phase_r))
    else $error("engine advanced while result stalled");

endmodule

### rtl/i2c_master_byte_engine.sv
// Open-drain I2C master that runs one byte command at a time (start, write
// with ACK check, read with ACK or NACK, stop). Every request is one clock
// tick with the sampled SDA level and returns exactly one result carrying the
// SCL/SDA drives, busy, a done pulse, the last read byte and a sticky
// missing-ACK flag. Throughput is one tick per cycle unless results stall:
// the bit engine takes one step per cycle from a four-entry tick queue, and
// results leave through a single output register. Commands arriving while
// busy are ignored; the user must write configuration only while idle, as
// the block itself does not enforce it.
module i2c_master_byte_engine import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  i2cm_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output i2cm_out_t  out_data
);

  logic       q_valid;
  logic       q_pop;
  i2cm_tick_t q_item;

  i2cm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  i2cm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### test/i2c_master_byte_engine_tb.sv
`timescale 1ns / 1ps

module i2c_master_byte_engine_tb;
  import i2cm_pkg::*;

  localparam logic [2:0] FUNC_TOP = 3'd7;  // highest code the 3-bit field can carry

  typedef enum logic [2:0] {
    BUS_IDLE, BUS_START, BUS_WRITE, BUS_WACK, BUS_POLL, BUS_READ, BUS_RACK, BUS_STOP
  } bus_phase_e;

  typedef struct {
    logic [15:0] half_period;
    logic [7:0]  ack_limit;
    bus_phase_e  phase;
    logic [2:0]  bit_idx;
    logic        half_step;
    logic [7:0]  shreg;
    logic [7:0]  wait_cnt;
    logic [15:0] div;
    logic        scl;
    logic        sda;
    logic        ack_sel;
    logic [7:0]  rx_hold;
    logic        ack_flag;
  } engine_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  i2cm_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  i2cm_out_t   out_data;

  i2cm_in_t      pendq[$];
  i2cm_out_t     expq[$];
  engine_state_t live_st;
  engine_state_t plan_st;

  bit          quiet = 1'b0;
  int unsigned hold_off = 0;
  int unsigned stall_left = 0;
  int unsigned errors = 0;
  int unsigned ticks_planned = 0;
  int unsigned ticks_accepted = 0;
  int unsigned done_seen = 0;
  int unsigned timeouts = 0;
  int unsigned reg_writes = 0;

  i2c_master_byte_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic engine_state_t fresh_state();
    engine_state_t s;
    s.half_period = HALF_PERIOD_RST;
    s.ack_limit   = ACK_TIMEOUT_RST;
    s.phase       = BUS_IDLE;
    s.bit_idx     = 3'd0;
    s.half_step   = 1'b0;
    s.shreg       = 8'd0;
    s.wait_cnt    = 8'd0;
    s.div         = 16'd0;
    s.scl         = 1'b1;
    s.sda         = 1'b1;
    s.ack_sel     = 1'b0;
    s.rx_hold     = 8'd0;
    s.ack_flag    = 1'b0;
    return s;
  endfunction

  function automatic void apply_reg(inout engine_state_t s, input logic idx,
                                    input logic [15:0] val);
    if (idx == CFG_HALF_PERIOD) s.half_period = val;
    else s.ack_limit = val[7:0];
  endfunction

  // advance the half-period divider; a zero setting behaves as one
  function automatic logic half_done(inout engine_state_t s);
    logic [15:0] span;
    span = (s.half_period == 16'd0) ? 16'd1 : s.half_period;
    s.div = s.div + 16'd1;
    if (s.div >= span) begin
      s.div = 16'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void enter_stop(inout engine_state_t s);
    s.phase   = BUS_STOP;
    s.bit_idx = 3'd0;
    s.div     = 16'd0;
    s.scl     = 1'b0;
    s.sda     = 1'b0;
  endfunction

  function automatic i2cm_out_t engine_tick(inout engine_state_t s, input i2cm_in_t it);
    i2cm_out_t r;
    logic      done;
    done = 1'b0;
    case (s.phase)
      BUS_IDLE: begin
        s.div = 16'd0;
        s.half_step = 1'b0;
        s.bit_idx = 3'd0;
        if (it.func == FUNC_START) begin
          s.phase = BUS_START;
          s.scl = 1'b1;
          s.sda = 1'b1;
        end else if (it.func == FUNC_WRITE) begin
          s.phase = BUS_WRITE;
          s.shreg = it.tx_byte;
          s.ack_flag = 1'b0;
          s.scl = 1'b0;
          s.sda = it.tx_byte[7];
        end else if (it.func == FUNC_READ) begin
          s.phase = BUS_READ;
          s.shreg = 8'd0;
          s.ack_sel = it.send_ack;
          s.scl = 1'b0;
          s.sda = 1'b1;
        end else if (it.func == FUNC_STOP) begin
          enter_stop(s);
        end
      end
      BUS_START: begin
        if (half_done(s)) begin
          if (!s.half_step) begin
            s.sda = 1'b0;
            s.half_step = 1'b1;
          end else begin
            s.scl = 1'b0;
            s.phase = BUS_IDLE;
            done = 1'b1;
          end
        end
      end
      BUS_WRITE: begin
        if (half_done(s)) begin
          if (!s.half_step) begin
            s.scl = 1'b1;
            s.half_step = 1'b1;
          end else begin
            s.scl = 1'b0;
            s.half_step = 1'b0;
            if (s.bit_idx == 3'd7) begin
              // release SDA while SCL is low, ahead of the ACK clock
              s.sda = 1'b1;
              s.phase = BUS_WACK;
            end else begin
              s.bit_idx = s.bit_idx + 3'd1;
              s.shreg = s.shreg << 1;
              s.sda = s.shreg[7];
            end
          end
        end
      end
      BUS_WACK: begin
        if (half_done(s)) begin
          if (!s.half_step) begin
            s.scl = 1'b1;
            s.half_step = 1'b1;
          end else begin
            s.phase = BUS_POLL;
            s.wait_cnt = 8'd0;
          end
        end
      end
      BUS_POLL: begin
        if (!it.sda_in) begin
          s.scl = 1'b0;
          s.phase = BUS_IDLE;
          done = 1'b1;
        end else if (s.wait_cnt >= s.ack_limit) begin
          s.ack_flag = 1'b1;
          enter_stop(s);
        end else begin
          s.wait_cnt = s.wait_cnt + 8'd1;
        end
      end
      BUS_READ: begin
        if (half_done(s)) begin
          if (!s.half_step) begin
            s.scl = 1'b1;
            s.half_step = 1'b1;
          end else begin
            s.shreg = {s.shreg[6:0], it.sda_in};
            s.scl = 1'b0;
            s.half_step = 1'b0;
            if (s.bit_idx == 3'd7) begin
              s.phase = BUS_RACK;
              s.sda = ~s.ack_sel;
            end else begin
              s.bit_idx = s.bit_idx + 3'd1;
            end
          end
        end
      end
      BUS_RACK: begin
        if (half_done(s)) begin
          if (!s.half_step) begin
            s.scl = 1'b1;
            s.half_step = 1'b1;
          end else begin
            s.scl = 1'b0;
            s.sda = 1'b1;
            s.rx_hold = s.shreg;
            s.phase = BUS_IDLE;
            done = 1'b1;
          end
        end
      end
      default: begin
        if (half_done(s)) begin
          if (s.bit_idx == 3'd0) begin
            s.scl = 1'b1;
            s.bit_idx = 3'd1;
          end else if (s.bit_idx == 3'd1) begin
            s.sda = 1'b1;
            s.bit_idx = 3'd2;
          end else begin
            s.phase = BUS_IDLE;
            s.bit_idx = 3'd0;
            done = 1'b1;
          end
        end
      end
    endcase
    r.scl_level   = s.scl;
    r.sda_release = s.sda;
    r.busy_res    = (s.phase != BUS_IDLE);
    r.cmd_done    = done;
    r.rx_byte     = s.rx_hold;
    r.ack_missing = s.ack_flag;
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // request driver: predict at acceptance, hold payload while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expq.push_back(engine_tick(live_st, in_data));
        ticks_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (hold_off > 0) begin
          hold_off--;
          in_valid <= 1'b0;
        end else if (pendq.size() > 0) begin
          in_data <= pendq.pop_front();
          in_valid <= 1'b1;
          hold_off = idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    i2cm_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expq.size() == 0) begin
          $display("%0t: unexpected result expected none got %p", $time, out_data);
          errors++;
        end else begin
          want = expq.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(out_data.scl_level));
          check_field("sda_release", 8'(want.sda_release), 8'(out_data.sda_release));
          check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
          check_field("cmd_done", 8'(want.cmd_done), 8'(out_data.cmd_done));
          check_field("rx_byte", want.rx_byte, out_data.rx_byte);
          check_field("ack_missing", 8'(want.ack_missing), 8'(out_data.ack_missing));
          if (out_data.cmd_done === 1'b1) done_seen++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = idle_len();
      end
    end
  end

  task automatic drain_all();
    while (pendq.size() != 0 || in_valid || expq.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    drain_all();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(live_st, idx, val);
    apply_reg(plan_st, idx, val);
    reg_writes++;
  endtask

  task automatic send_tick(input logic [2:0] f, input logic [7:0] tx, input logic ack,
                           input logic sda);
    i2cm_in_t it;
    it.func = f;
    it.tx_byte = tx;
    it.send_ack = ack;
    it.sda_in = sda;
    while (pendq.size() >= 64) @(posedge clk);
    pendq.push_back(it);
    void'(engine_tick(plan_st, it));
    ticks_planned++;
  endtask

  // sda_mode: 0 hold low, 1 hold high, otherwise random
  function automatic logic pick_sda(input int mode);
    if (mode == 0) return 1'b0;
    if (mode == 1) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  // issue one command, then tick until the engine is idle again; the slave
  // pulls SDA low once ack_delay high samples have been polled
  task automatic do_cmd(input logic [2:0] f, input logic [7:0] tx, input logic ack,
                        input int sda_mode, input int ack_delay);
    logic sda;
    send_tick(f, tx, ack, pick_sda(sda_mode));
    while (plan_st.phase != BUS_IDLE) begin
      if (plan_st.phase == BUS_POLL) sda = (plan_st.wait_cnt >= ack_delay) ? 1'b0 : 1'b1;
      else sda = pick_sda(sda_mode);
      // commands here arrive while busy and must be dropped
      send_tick(3'($urandom_range(0, FUNC_TOP)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), sda);
    end
    if (f == FUNC_WRITE && plan_st.ack_flag) timeouts++;
  endtask

  function automatic int slave_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 2);
    if (r < 70) return $urandom_range(0, plan_st.ack_limit);
    if (r < 80) return plan_st.ack_limit;
    if (r < 88) return plan_st.ack_limit + 1;
    return 1000;
  endfunction

  initial begin
    logic [15:0] hp_set [4];
    logic [15:0] lim_set [4];
    int unsigned mark;
    int unsigned nw;
    int unsigned nr;
    int unsigned i;
    int c;
    bit lost;

    hp_set  = '{16'd1, 16'd2, 16'd1, 16'd2};
    lim_set = '{16'h0003, 16'h7F05, 16'h0001, 16'h000C};
    live_st = fresh_state();
    plan_st = fresh_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: half period 1, ack timeout 250
    do_cmd(FUNC_NONE, 8'h00, 1'b0, 2, 0);
    for (c = FUNC_STOP + 1; c <= FUNC_TOP; c++) do_cmd(3'(c), 8'hFF, 1'b1, 2, 0);
    do_cmd(FUNC_START, 8'h00, 1'b0, 2, 0);
    do_cmd(FUNC_WRITE, 8'hFF, 1'b0, 2, 0);
    do_cmd(FUNC_WRITE, 8'h00, 1'b1, 2, 2);
    do_cmd(FUNC_READ, 8'h00, 1'b1, 1, 0);
    do_cmd(FUNC_READ, 8'hFF, 1'b0, 0, 0);
    do_cmd(FUNC_WRITE, 8'h5A, 1'b1, 2, 0);
    do_cmd(FUNC_READ, 8'h3C, 1'b1, 2, 0);
    do_cmd(FUNC_STOP, 8'h00, 1'b0, 2, 0);

    // zero half period acts as one; timeout of zero fails on first high sample
    write_reg(CFG_HALF_PERIOD, 16'h0000);
    write_reg(CFG_ACK_TIMEOUT, 16'hC300);
    do_cmd(FUNC_START, 8'h00, 1'b0, 2, 0);
    do_cmd(FUNC_WRITE, 8'h81, 1'b0, 2, 1000);
    do_cmd(FUNC_WRITE, 8'h7E, 1'b0, 2, 0);
    do_cmd(FUNC_STOP, 8'h00, 1'b0, 2, 0);

    // timeout edge: ACK on the last allowed sample, then one too late
    write_reg(CFG_HALF_PERIOD, 16'd1);
    write_reg(CFG_ACK_TIMEOUT, 16'h0006);
    do_cmd(FUNC_START, 8'h00, 1'b0, 2, 0);
    do_cmd(FUNC_WRITE, 8'hC3, 1'b0, 2, 6);
    do_cmd(FUNC_WRITE, 8'h18, 1'b0, 2, 7);
    do_cmd(FUNC_STOP, 8'h00, 1'b0, 2, 0);

    foreach (hp_set[p]) begin
      write_reg(CFG_HALF_PERIOD, hp_set[p]);
      write_reg(CFG_ACK_TIMEOUT, lim_set[p]);
      mark = ticks_planned;
      quiet = 1'b1;
      while (ticks_planned - mark < 30) begin
        if (ticks_planned - mark > 10) quiet = 1'b0;
        if ($urandom_range(0, 99) < 80) begin
          // start, address and data writes, reads, then stop or repeated start
          do_cmd(FUNC_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2, 0);
          nw = $urandom_range(1, 2);
          nr = $urandom_range(0, 2);
          lost = 1'b0;
          for (i = 0; i < nw && !lost; i++) begin
            do_cmd(FUNC_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2,
                   slave_delay());
            lost = plan_st.ack_flag;
          end
          for (i = 0; i < nr && !lost; i++)
            do_cmd(FUNC_READ, 8'($urandom_range(0, 255)), (i + 1 < nr) ? 1'b1 : 1'b0, 2, 0);
          if (!lost) begin
            if ($urandom_range(0, 9) == 0) do_cmd(FUNC_START, 8'h00, 1'b0, 2, 0);
            else do_cmd(FUNC_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2, 0);
          end
        end else begin
          // stray command outside any transaction
          do_cmd(3'($urandom_range(0, FUNC_TOP)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 2, slave_delay());
        end
        repeat ($urandom_range(0, 2))
          send_tick(($urandom_range(0, 3) == 0) ? FUNC_NONE :
                    3'($urandom_range(FUNC_STOP + 1, FUNC_TOP)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        // hold off now and then until every result is back
        if ($urandom_range(0, 19) == 0) drain_all();
      end
    end

    drain_all();
    repeat (8) @(posedge clk);
    $display("covered %0d ticks over %0d register writes: %0d commands completed, %0d ack timeouts",
             ticks_accepted, reg_writes, done_seen, timeouts);
    if (errors == 0 && expq.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (expq.size() != 0) $display("%0t: %0d results never arrived", $time, expq.size());
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: run timed out", $time);
    $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_engine.sv
rtl/i2c_master_byte_engine.sv
test/i2c_master_byte_engine_tb.sv
